// ===== sv/easter_feast_date_calc_top_defines.svh =====
// assertion macros for the feast date calculator
`ifndef EASTER_FEAST_DATE_CALC_TOP_DEFINES_SVH
`define EASTER_FEAST_DATE_CALC_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define EFDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define EFDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/efdc_pkg.sv =====
// shared types, constants and helper functions of the feast date calculator
package efdc_pkg;

    localparam int YEAR_W = 16;
    localparam int OP_W   = 3;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;

    // pipeline stage indices
    localparam int ST_IN   = 0;
    localparam int ST_DIV  = 1;
    localparam int ST_REM  = 2;
    localparam int ST_G    = 3;
    localparam int ST_X    = 4;
    localparam int ST_H    = 5;
    localparam int ST_L    = 6;
    localparam int ST_BASE = 7;
    localparam int ST_DOY  = 8;
    localparam int ST_OUT  = 9;
    localparam int NSTG    = 10;

    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_pipe_ctl;

    // feast selectors
    localparam logic [OP_W-1:0] OP_EASTER      = 3'd0;
    localparam logic [OP_W-1:0] OP_CARNIVAL    = 3'd1;
    localparam logic [OP_W-1:0] OP_GOOD_FRIDAY = 3'd2;
    localparam logic [OP_W-1:0] OP_ASCENSION   = 3'd3;
    localparam logic [OP_W-1:0] OP_WHITSUN     = 3'd4;

    // months
    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_MAR = 4'd3;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_MAY = 4'd5;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_JUL = 4'd7;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;

    // last day of year of each month from january to june in a common year
    localparam logic [7:0] CUM_JAN = 8'd31;
    localparam logic [7:0] CUM_FEB = 8'd59;
    localparam logic [7:0] CUM_MAR = 8'd90;
    localparam logic [7:0] CUM_APR = 8'd120;
    localparam logic [7:0] CUM_MAY = 8'd151;
    localparam logic [7:0] CUM_JUN = 8'd181;

    // reciprocals for constant division, quotient = (x * rcp) >> sh
    localparam logic [16:0] RCP_100 = 17'd83887;
    localparam int          SH_100  = 23;
    localparam logic [15:0] RCP_19  = 16'd55189;
    localparam int          SH_19   = 20;
    localparam logic [9:0]  RCP_25  = 10'd656;
    localparam int          SH_25   = 14;
    localparam logic [9:0]  RCP_3   = 10'd683;
    localparam int          SH_3    = 11;
    localparam logic [10:0] RCP_30  = 11'd1093;
    localparam int          SH_30   = 15;

    localparam int  CARNIVAL_SPAN = 2;

    // remainder by 7 of a 7-bit value by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [6:0] v);
        logic [3:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = {3'b000, v[6]} + {1'b0, v[5:3]} + {1'b0, v[2:0]};
        s2 = {3'b000, s1[3]} + {1'b0, s1[2:0]};
        r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
        return r[2:0];
    endfunction

    // day offset of a feast from easter sunday
    function automatic logic signed [6:0] feast_ofs(input logic [OP_W-1:0] op);
        logic signed [6:0] o;
        case (op)
            OP_CARNIVAL: begin
                o = -7'sd49;
            end
            OP_GOOD_FRIDAY: begin
                o = -7'sd2;
            end
            OP_ASCENSION: begin
                o = 7'sd39;
            end
            OP_WHITSUN: begin
                o = 7'sd49;
            end
            default: begin
                o = 7'sd0;
            end
        endcase
        return o;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mm,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        if (mm == MON_FEB) begin
            n = 5'd28 + {4'b0000, leap};
        end else if (mm inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}) begin
            n = 5'd30;
        end else begin
            n = 5'd31;
        end
        return n;
    endfunction

endpackage

// ===== sv/efdc_cmpt.sv =====
// computus pipeline: year to easter month flag, easter day and leap flag
module efdc_cmpt (
    input  logic                        i_clk,
    input  efdc_pkg::t_pipe_ctl         i_ctl,
    input  logic [efdc_pkg::YEAR_W-1:0] i_year,
    input  logic [efdc_pkg::OP_W-1:0]   i_op,
    output logic                        o_apr,
    output logic [efdc_pkg::DAY_W-1:0]  o_eday,
    output logic                        o_leap,
    output logic [efdc_pkg::OP_W-1:0]   o_op
);
    import efdc_pkg::*;

    // stage 1: century and cycle quotients
    logic [32:0] p100;
    logic [31:0] p19;
    logic [YEAR_W-1:0] r1_year;
    logic [9:0]  r1_b;
    logic [11:0] r1_q19;
    logic [OP_W-1:0] r1_op;

    assign p100 = 33'(i_year) * 33'(RCP_100);
    assign p19  = 32'(i_year) * 32'(RCP_19);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_DIV]) begin
            r1_year <= i_year;
            r1_b    <= p100[SH_100 +: 10];
            r1_q19  <= p19[SH_19 +: 12];
            r1_op   <= i_op;
        end
    end

    // stage 2: remainders and f
    logic [16:0] t100;
    logic [16:0] t19;
    logic [9:0]  bf;
    logic [19:0] pf;
    logic [4:0]  r2_a;
    logic [9:0]  r2_b;
    logic [6:0]  r2_c;
    logic [4:0]  r2_f;
    logic [OP_W-1:0] r2_op;

    assign t100 = {1'b0, r1_year} - 17'(r1_b) * 17'd100;
    assign t19  = {1'b0, r1_year} - 17'(r1_q19) * 17'd19;
    assign bf   = r1_b + 10'd8;
    assign pf   = 20'(bf) * 20'(RCP_25);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_REM]) begin
            r2_a  <= t19[4:0];
            r2_b  <= r1_b;
            r2_c  <= t100[6:0];
            r2_f  <= pf[SH_25 +: 5];
            r2_op <= r1_op;
        end
    end

    // stage 3: g, leap year, c split
    logic [9:0]  gn;
    logic [20:0] pg;
    logic        leap;
    logic [4:0]  r3_a;
    logic [9:0]  r3_b;
    logic [7:0]  r3_g;
    logic [4:0]  r3_i;
    logic [1:0]  r3_k;
    logic        r3_leap;
    logic [OP_W-1:0] r3_op;

    assign gn   = r2_b - 10'(r2_f) + 10'd1;
    assign pg   = 21'(gn) * 21'(RCP_3);
    // divisible by 4, and not a century unless the century is divisible by 4
    assign leap = (r2_c[1:0] == 2'b00) && ((r2_c != 7'd0) || (r2_b[1:0] == 2'b00));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_G]) begin
            r3_a    <= r2_a;
            r3_b    <= r2_b;
            r3_g    <= pg[SH_3 +: 8];
            r3_i    <= r2_c[6:2];
            r3_k    <= r2_c[1:0];
            r3_leap <= leap;
            r3_op   <= r2_op;
        end
    end

    // stage 4: epact sum and its quotient by 30
    logic [10:0] xs;
    logic [20:0] px;
    logic [9:0]  r4_x;
    logic [5:0]  r4_qx;
    logic [4:0]  r4_a;
    logic [1:0]  r4_e;
    logic [4:0]  r4_i;
    logic [1:0]  r4_k;
    logic        r4_leap;
    logic [OP_W-1:0] r4_op;

    assign xs = 11'(r3_a) * 11'd19 + 11'(r3_b) - 11'(r3_b[9:2]) - 11'(r3_g) + 11'd15;
    assign px = 21'(xs[9:0]) * 21'(RCP_30);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_X]) begin
            r4_x    <= xs[9:0];
            r4_qx   <= px[SH_30 +: 6];
            r4_a    <= r3_a;
            r4_e    <= r3_b[1:0];
            r4_i    <= r3_i;
            r4_k    <= r3_k;
            r4_leap <= r3_leap;
            r4_op   <= r3_op;
        end
    end

    // stage 5: h and the weekday sum
    logic [9:0] hx;
    logic [7:0] vs;
    logic [4:0] r5_h;
    logic [6:0] r5_v;
    logic [4:0] r5_a;
    logic       r5_leap;
    logic [OP_W-1:0] r5_op;

    assign hx = r4_x - 10'(r4_qx) * 10'd30;
    assign vs = 8'd32 + 8'({r4_e, 1'b0}) + 8'({r4_i, 1'b0}) - 8'(hx[4:0]) - 8'(r4_k);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_H]) begin
            r5_h    <= hx[4:0];
            r5_v    <= vs[6:0];
            r5_a    <= r4_a;
            r5_leap <= r4_leap;
            r5_op   <= r4_op;
        end
    end

    // stage 6: l
    logic [4:0] r6_h;
    logic [2:0] r6_l;
    logic [4:0] r6_a;
    logic       r6_leap;
    logic [OP_W-1:0] r6_op;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_L]) begin
            r6_h    <= r5_h;
            r6_l    <= mod7(r5_v);
            r6_a    <= r5_a;
            r6_leap <= r5_leap;
            r6_op   <= r5_op;
        end
    end

    // stage 7: correction m, easter month and day
    logic [9:0] ms;
    logic       mc;
    logic [7:0] base;
    logic       apr;
    logic [7:0] eday;
    logic       r7_apr;
    logic [DAY_W-1:0] r7_eday;
    logic       r7_leap;
    logic [OP_W-1:0] r7_op;

    assign ms   = 10'(r6_a) + 10'(r6_h) * 10'd11 + 10'(r6_l) * 10'd22;
    assign mc   = (ms >= 10'd451);
    assign base = 8'(r6_h) + 8'(r6_l) + 8'd114 - (mc ? 8'd7 : 8'd0);
    assign apr  = (base >= 8'd124);
    assign eday = apr ? (base - 8'd123) : (base - 8'd92);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_BASE]) begin
            r7_apr  <= apr;
            r7_eday <= eday[DAY_W-1:0];
            r7_leap <= r6_leap;
            r7_op   <= r6_op;
        end
    end

    assign o_apr  = r7_apr;
    assign o_eday = r7_eday;
    assign o_leap = r7_leap;
    assign o_op   = r7_op;

endmodule

// ===== sv/efdc_date.sv =====
// date stages: easter plus feast offset to day of year, then back to day and month
module efdc_date (
    input  logic                        i_clk,
    input  efdc_pkg::t_pipe_ctl         i_ctl,
    input  logic                        i_apr,
    input  logic [efdc_pkg::DAY_W-1:0]  i_eday,
    input  logic                        i_leap,
    input  logic [efdc_pkg::OP_W-1:0]   i_op,
    output logic [efdc_pkg::DAY_W-1:0]  o_day,
    output logic [efdc_pkg::MON_W-1:0]  o_month_num,
    output logic [efdc_pkg::DAY_W-1:0]  o_end_day,
    output logic [efdc_pkg::MON_W-1:0]  o_end_month
);
    import efdc_pkg::*;

    // day of year of the feast
    logic signed [9:0] doy_s;
    logic [7:0] r8_doy;
    logic       r8_leap;
    logic [OP_W-1:0] r8_op;

    assign doy_s = $signed({5'b00000, i_eday}) + $signed(10'(CUM_FEB))
                 + $signed({9'b0, i_leap}) + (i_apr ? 10'sd31 : 10'sd0)
                 + 10'(feast_ofs(i_op));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_DOY]) begin
            r8_doy  <= doy_s[7:0];
            r8_leap <= i_leap;
            r8_op   <= i_op;
        end
    end

    // month search over cumulative month ends
    logic [7:0] lp;
    logic [7:0] dd8;
    logic [MON_W-1:0] mm;
    logic [DAY_W-1:0] mlen;
    logic [5:0] ed6;
    logic [5:0] edw;
    logic [DAY_W-1:0] n_end_day;
    logic [MON_W-1:0] n_end_month;
    logic [DAY_W-1:0] r9_day;
    logic [MON_W-1:0] r9_month;
    logic [DAY_W-1:0] r9_end_day;
    logic [MON_W-1:0] r9_end_month;

    assign lp = 8'(r8_leap);

    always_comb begin
        if (r8_doy <= CUM_JAN) begin
            mm  = MON_JAN;
            dd8 = r8_doy;
        end else if (r8_doy <= CUM_FEB + lp) begin
            mm  = MON_FEB;
            dd8 = r8_doy - CUM_JAN;
        end else if (r8_doy <= CUM_MAR + lp) begin
            mm  = MON_MAR;
            dd8 = r8_doy - CUM_FEB - lp;
        end else if (r8_doy <= CUM_APR + lp) begin
            mm  = MON_APR;
            dd8 = r8_doy - CUM_MAR - lp;
        end else if (r8_doy <= CUM_MAY + lp) begin
            mm  = MON_MAY;
            dd8 = r8_doy - CUM_APR - lp;
        end else if (r8_doy <= CUM_JUN + lp) begin
            mm  = MON_JUN;
            dd8 = r8_doy - CUM_MAY - lp;
        end else begin
            mm  = MON_JUL;
            dd8 = r8_doy - CUM_JUN - lp;
        end
    end

    // carnival end date, two days on, may roll into the next month
    assign mlen = month_len(mm, r8_leap);
    assign ed6  = 6'(dd8[DAY_W-1:0]) + 6'(CARNIVAL_SPAN);
    assign edw  = ed6 - 6'(mlen);

    always_comb begin
        n_end_day   = dd8[DAY_W-1:0];
        n_end_month = mm;
        if (r8_op == OP_CARNIVAL) begin
            if (ed6 > 6'(mlen)) begin
                n_end_day   = edw[DAY_W-1:0];
                n_end_month = mm + 4'd1;
            end else begin
                n_end_day   = ed6[DAY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_OUT]) begin
            r9_day       <= dd8[DAY_W-1:0];
            r9_month     <= mm;
            r9_end_day   <= n_end_day;
            r9_end_month <= n_end_month;
        end
    end

    assign o_day       = r9_day;
    assign o_month_num = r9_month;
    assign o_end_day   = r9_end_day;
    assign o_end_month = r9_end_month;

endmodule

// ===== sv/easter_feast_date_calc_top.sv =====
// top level of the feast date calculator: handshake control, input register, datapath
//
//  channel   dir   handshake            payload
//  request   in    i_valid / o_stall    i_year[15:0], i_op[2:0]
//  result    out   o_valid / i_stall    o_day[4:0], o_month_num[3:0],
//                                       o_end_day[4:0], o_end_month[3:0]
//
//  one request per cycle sustained while i_stall stays low
//  ten-register pipeline: input register, seven computus stages, two date stages
//  i_rst_n is synchronous and clears only the stage valid bits
//  a stage holds its request while the stage after it is full and held
//  o_stall rises only when all ten stages are full and i_stall holds the output
module easter_feast_date_calc_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [efdc_pkg::YEAR_W-1:0] i_year,
    input  logic [efdc_pkg::OP_W-1:0]   i_op,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [efdc_pkg::DAY_W-1:0]  o_day,
    output logic [efdc_pkg::MON_W-1:0]  o_month_num,
    output logic [efdc_pkg::DAY_W-1:0]  o_end_day,
    output logic [efdc_pkg::MON_W-1:0]  o_end_month
);
    import efdc_pkg::*;

    `include "easter_feast_date_calc_top_defines.svh"

    // one valid bit per stage
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] stg_en;
    t_pipe_ctl       ctl;

    // input register
    logic [YEAR_W-1:0] r_year;
    logic [OP_W-1:0]   r_op;

    // cmpt to date handoff
    logic              apr;
    logic [DAY_W-1:0]  eday;
    logic              leap;
    logic [OP_W-1:0]   op7;

    // result date lies in the window every feast can reach
    logic              res_date_ok;

    // a stage may load when it is empty or when its own request moves on
    always_comb begin
        stg_en[ST_OUT] = !r_vld[ST_OUT] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    // valid bits shift with the enables, bubbles collapse
    always_comb begin
        n_vld = r_vld;
        if (stg_en[ST_IN]) begin
            n_vld[ST_IN] = i_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // request capture, no reset on payload
    always_ff @(posedge i_clk) begin
        if (stg_en[ST_IN]) begin
            r_year <= i_year;
            r_op   <= i_op;
        end
    end

    assign ctl.en  = stg_en;
    assign o_stall = !stg_en[ST_IN];
    assign o_valid = r_vld[ST_OUT];

    // easter sunday of the year
    efdc_cmpt u_cmpt (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_year (r_year),
        .i_op   (r_op),
        .o_apr  (apr),
        .o_eday (eday),
        .o_leap (leap),
        .o_op   (op7)
    );

    // feast offset and calendar conversion, ends in the result register
    efdc_date u_date (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_apr       (apr),
        .i_eday      (eday),
        .i_leap      (leap),
        .i_op        (op7),
        .o_day       (o_day),
        .o_month_num (o_month_num),
        .o_end_day   (o_end_day),
        .o_end_month (o_end_month)
    );

    assign res_date_ok = (o_month_num >= MON_FEB) && (o_month_num <= MON_JUN)
                       && (o_day != 5'd0);

    // input is held off only when every stage holds a request
    `EFDC_ASSERT_NOW(a_stall_full, o_stall, &r_vld, "request stalled with a free stage")
    // feasts fall between february and june
    `EFDC_ASSERT_NOW(a_month_range, o_valid, res_date_ok, "result date out of range")
    // end date is in the same month or the next one
    `EFDC_ASSERT_NOW(a_end_month, o_valid, (o_end_month == o_month_num) || (o_end_month == o_month_num + 4'd1), "end month out of range")
    // a taken result is replaced at once by a waiting one
    `EFDC_ASSERT_NEXT(a_refill, o_valid && !i_stall && r_vld[ST_DOY], o_valid, "result register not refilled")

endmodule
